// File: hw/rtl/psh_pkg.sv
// ----------------------------------------------------------------------------
// psh_pkg
// Shared types and constants for the palette lookup with shadow and highlight.
// ----------------------------------------------------------------------------
package psh_pkg;

	localparam int RAM_DEPTH = 64;
	localparam int RAM_AW    = 6;
	localparam int COLOR_W   = 12;
	localparam int PIXEL_W   = 16;
	localparam int RGB_W     = 24;
	localparam int NIB_W     = 4;
	localparam int CHAN_W    = 8;

	localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

	// item modes
	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_PIXEL = 1'b1;

	// pixel word fields
	localparam int PW_SHADOW_BIT    = 14;
	localparam int PW_HIGHLIGHT_BIT = 13;

	localparam logic [1:0] PAL_EFFECT       = 2'd3;
	localparam logic [3:0] IDX_ZERO         = 4'd0;
	localparam logic [3:0] IDX_SHADOW_PX    = 4'd14;
	localparam logic [3:0] IDX_HIGHLIGHT_PX = 4'd15;

	typedef enum logic [1:0] {
		EFF_NONE      = 2'd0,
		EFF_SHADOW    = 2'd1,
		EFF_HIGHLIGHT = 2'd2
	} effect_t;

	typedef struct packed {
		effect_t effect;
		logic    shadow_px;
		logic    highlight_px;
	} pix_ctl_t;

endpackage

// File: hw/rtl/psh_if.sv
// ----------------------------------------------------------------------------
// psh_if
// Valid/ready channels for pixel and write items and for converted results.
// ----------------------------------------------------------------------------
interface psh_pixel_if
	import psh_pkg::*;
();
	logic               valid;
	logic               ready;
	logic               mode;
	logic [RAM_AW-1:0]  ram_address;
	logic [COLOR_W-1:0] ram_color;
	logic [PIXEL_W-1:0] pixel_word;

	modport source (output valid, mode, ram_address, ram_color, pixel_word, input ready);
	modport sink   (input valid, mode, ram_address, ram_color, pixel_word, output ready);
endinterface

interface psh_result_if
	import psh_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [RGB_W-1:0] rgb;
	logic             shadow_effect_pixel;
	logic             highlight_effect_pixel;

	modport source (output valid, rgb, shadow_effect_pixel, highlight_effect_pixel,
		input ready);
	modport sink   (input valid, rgb, shadow_effect_pixel, highlight_effect_pixel,
		output ready);
endinterface

// File: hw/rtl/palette_pixel_to_rgb_shadow_highlight_core.sv
// ----------------------------------------------------------------------------
// palette_pixel_to_rgb_shadow_highlight_core
// Color RAM lookup of pixel words to 24-bit RGB with shadow and highlight.
// ----------------------------------------------------------------------------
// Usage:
//   pixel  - valid/ready input; mode 0 writes ram_color into entry ram_address,
//            mode 1 converts pixel_word through the color RAM
//   result - valid/ready output; one transfer per converted pixel, none per write
//   cfg_we / cfg_wdata - sets the shadow/highlight enable register; write only
//            while no pixel is in flight
// Path: an accepted pixel passes the RAM read register, then the output
//   register, before it shows on result.
// Throughput: one item per cycle while result is taken, set by the single
//   RAM port pair (one write and one read each cycle); a write followed by a
//   read of the same entry in the next cycle sees the new color.
// Reset: the color RAM reads as all zero and the enable register is cleared;
//   the block takes items right after reset.
// Stall: when result is not taken the output register holds, the read stage
//   still takes one more item, then pixel.ready drops until result drains.
// ----------------------------------------------------------------------------
module palette_pixel_to_rgb_shadow_highlight_core
	import psh_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_wdata,
	psh_pixel_if.sink           pixel,
	psh_result_if.source        result
);

	logic               enable_q;
	logic               accept;
	logic               wr_en;
	logic               rd_en;
	logic [3:0]         idx;
	logic [1:0]         pal;
	logic [RAM_AW-1:0]  entry;
	logic               apply;
	pix_ctl_t           ctl_next;
	logic               valid_s1;
	pix_ctl_t           ctl_s1;
	logic [COLOR_W-1:0] color_s1;
	logic               s1_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
		end else if (cfg_we) begin
			enable_q <= cfg_wdata;
		end
	end

	assign pixel.ready = !valid_s1 || s1_take;
	assign accept      = pixel.valid && pixel.ready;
	assign wr_en       = accept && (pixel.mode == MODE_WRITE);
	assign rd_en       = accept && (pixel.mode == MODE_PIXEL);

	assign idx   = pixel.pixel_word[3:0];
	assign pal   = pixel.pixel_word[5:4];
	// index zero is the shared backdrop entry
	assign entry = (idx == IDX_ZERO) ? '0 : {pal, idx};
	assign apply = (idx == IDX_ZERO) || enable_q;

	always_comb begin
		ctl_next.effect = EFF_NONE;
		priority if (apply && pixel.pixel_word[PW_SHADOW_BIT]) begin
			ctl_next.effect = EFF_SHADOW;
		end else if (apply && pixel.pixel_word[PW_HIGHLIGHT_BIT]) begin
			ctl_next.effect = EFF_HIGHLIGHT;
		end else begin
			ctl_next.effect = EFF_NONE;
		end
		ctl_next.shadow_px    = (pal == PAL_EFFECT) && (idx == IDX_SHADOW_PX);
		ctl_next.highlight_px = (pal == PAL_EFFECT) && (idx == IDX_HIGHLIGHT_PX);
	end

	psh_color_ram u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (pixel.ram_address),
		.wr_data (pixel.ram_color),
		.rd_en   (rd_en),
		.rd_addr (entry),
		.rd_data (color_s1)
	);

	// write items leave the pipe here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pixel.ready) begin
			valid_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			ctl_s1 <= ctl_next;
		end
	end

	psh_shade u_shade (
		.clk              (clk),
		.arst_n           (arst_n),
		.s1_valid         (valid_s1),
		.s1_ctl           (ctl_s1),
		.s1_color         (color_s1),
		.s1_take          (s1_take),
		.out_valid        (result.valid),
		.out_ready        (result.ready),
		.out_rgb          (result.rgb),
		.out_shadow_px    (result.shadow_effect_pixel),
		.out_highlight_px (result.highlight_effect_pixel)
	);

endmodule

// File: hw/rtl/psh_color_ram.sv
// ----------------------------------------------------------------------------
// psh_color_ram
// 64 x 12 color RAM, one write and one registered read port per cycle.
// ----------------------------------------------------------------------------
module psh_color_ram
	import psh_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [RAM_AW-1:0]  wr_addr,
	input  logic [COLOR_W-1:0] wr_data,
	input  logic               rd_en,
	input  logic [RAM_AW-1:0]  rd_addr,
	output logic [COLOR_W-1:0] rd_data
);

	logic [COLOR_W-1:0]   mem [RAM_DEPTH];
	logic [RAM_DEPTH-1:0] written_q;
	logic [COLOR_W-1:0]   rd_data_q;

	// entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (wr_en) begin
			written_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= written_q[rd_addr] ? mem[rd_addr] : '0;
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: hw/rtl/psh_shade.sv
// ----------------------------------------------------------------------------
// psh_shade
// Nibble expansion, shadow or highlight, and the result output register.
// ----------------------------------------------------------------------------
module psh_shade
	import psh_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s1_valid,
	input  pix_ctl_t           s1_ctl,
	input  logic [COLOR_W-1:0] s1_color,
	output logic               s1_take,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [RGB_W-1:0]   out_rgb,
	output logic               out_shadow_px,
	output logic               out_highlight_px
);

	function automatic logic [CHAN_W-1:0] shade_chan(input logic [NIB_W-1:0] nib,
		input effect_t eff);
		logic [CHAN_W-1:0] c8;
		logic [CHAN_W:0]   hsum;
		c8   = {nib, nib};
		hsum = {1'b0, c8} + {3'b000, c8[CHAN_W-1:2]};
		unique case (eff)
			EFF_SHADOW:    shade_chan = {1'b0, c8[CHAN_W-1:1]};
			EFF_HIGHLIGHT: shade_chan = hsum[CHAN_W] ? CHAN_MAX : hsum[CHAN_W-1:0];
			default:       shade_chan = c8;
		endcase
	endfunction

	logic               valid_q;
	logic [RGB_W-1:0]   rgb_q;
	logic               shadow_px_q;
	logic               highlight_px_q;
	logic [RGB_W-1:0]   rgb_next;

	always_comb begin
		rgb_next = {shade_chan(s1_color[11:8], s1_ctl.effect),
			shade_chan(s1_color[7:4], s1_ctl.effect),
			shade_chan(s1_color[3:0], s1_ctl.effect)};
	end

	assign s1_take = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (s1_take) begin
			valid_q <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_take && s1_valid) begin
			rgb_q          <= rgb_next;
			shadow_px_q    <= s1_ctl.shadow_px;
			highlight_px_q <= s1_ctl.highlight_px;
		end
	end

	assign out_valid        = valid_q;
	assign out_rgb          = rgb_q;
	assign out_shadow_px    = shadow_px_q;
	assign out_highlight_px = highlight_px_q;

endmodule
